FILE: src/assert_macros.svh
// Assertion macros for the glyph row expansion blit.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GRE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define GRE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define GRE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GRE_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: src/gre_pkg.sv
// Shared types and constants for the glyph row expansion blit.
// No dependencies.
package gre_pkg;

   localparam int MAX_GLYPH_WIDTH_DEF = 64;
   localparam int GEO_W               = 18;
   localparam int SKIP_W              = 6;
   localparam int COLS_W              = 7;
   localparam int CSR_IDX_W           = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLIP_LEFT      = 4'd0,
      CSR_CLIP_TOP       = 4'd1,
      CSR_CLIP_RIGHT     = 4'd2,
      CSR_CLIP_BOTTOM    = 4'd3,
      CSR_DEST_PITCH     = 4'd4,
      CSR_FORE_COLOR     = 4'd5,
      CSR_PEN_START_X    = 4'd6,
      CSR_PEN_BASELINE_Y = 4'd7
   } csr_idx_type;

   typedef struct packed {
      logic signed [15:0] clip_left;
      logic signed [15:0] clip_top;
      logic signed [15:0] clip_right;
      logic signed [15:0] clip_bottom;
      logic signed [15:0] pen_baseline_y;
   } clip_cfg_type;

   typedef struct packed {
      logic              visible;
      logic [SKIP_W-1:0] skip;
      logic [COLS_W-1:0] cols;
      logic [15:0]       dy;
      logic [15:0]       dx;
   } geo_type;

endpackage

FILE: src/gre_ifs.sv
// Channel interfaces for the glyph row expansion blit: request, response, csr write.
// Depends on gre_pkg.
interface gre_req_if #(parameter int W = gre_pkg::MAX_GLYPH_WIDTH_DEF) ();
   logic                valid;
   logic                ready;
   logic                start_of_string;
   logic [W-1:0]        row_bits;
   logic [6:0]          glyph_width;
   logic [5:0]          row_number;
   logic signed [7:0]   bearing_x;
   logic signed [7:0]   bearing_y;
   logic [7:0]          advance_x;
   logic                last_row;
   modport source (output valid, start_of_string, row_bits, glyph_width, row_number,
                   bearing_x, bearing_y, advance_x, last_row, input ready);
   modport sink (input valid, start_of_string, row_bits, glyph_width, row_number,
                 bearing_x, bearing_y, advance_x, last_row, output ready);
endinterface

interface gre_rsp_if #(parameter int W = gre_pkg::MAX_GLYPH_WIDTH_DEF) ();
   logic         valid;
   logic         ready;
   logic [31:0]  dest_offset;
   logic [W-1:0] write_mask;
   logic [7:0]   pixel_color;
   modport source (output valid, dest_offset, write_mask, pixel_color, input ready);
   modport sink (input valid, dest_offset, write_mask, pixel_color, output ready);
endinterface

interface gre_csr_if ();
   logic                           valid;
   logic                           ready;
   logic [gre_pkg::CSR_IDX_W-1:0]  index;
   logic [15:0]                    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: src/gre_clip.sv
// Glyph row placement and clipping against the target rectangle.
// Depends on gre_pkg.
module gre_clip (
   input  logic signed [15:0]       pen,
   input  logic [6:0]               width,
   input  logic [5:0]               row,
   input  logic signed [7:0]        bx,
   input  logic signed [7:0]        by,
   input  gre_pkg::clip_cfg_type    cfg,
   output gre_pkg::geo_type         geo
);

   localparam int GW = gre_pkg::GEO_W;

   logic signed [GW-1:0] left, right, y, cl, cr;
   logic signed [GW-1:0] cleft, cright, ctop, cbot;
   logic signed [GW-1:0] skip_w, cols_w, dy_w, dx_w;

   always_comb begin
      cleft  = GW'(cfg.clip_left);
      cright = GW'(cfg.clip_right);
      ctop   = GW'(cfg.clip_top);
      cbot   = GW'(cfg.clip_bottom);
      left   = GW'(pen) + GW'(bx);
      right  = left + GW'($signed({1'b0, width}));
      y      = GW'(cfg.pen_baseline_y) - GW'(by) + GW'($signed({1'b0, row}));
      cl     = (left > cleft) ? left : cleft;
      cr     = (right < cright) ? right : cright;
      skip_w = cl - left;
      cols_w = cr - cl;
      dy_w   = y - ctop;
      dx_w   = cl - cleft;
      geo.visible = (cl < cr) && (y >= ctop) && (y < cbot);
      geo.skip    = skip_w[gre_pkg::SKIP_W-1:0];
      geo.cols    = cols_w[gre_pkg::COLS_W-1:0];
      geo.dy      = dy_w[15:0];
      geo.dx      = dx_w[15:0];
   end

endmodule

FILE: src/glyph_row_expand_blit.sv
// Top level of the glyph row expansion blit: csr bank, pen, three-register pipeline.
// Depends on gre_pkg, gre_ifs, gre_clip and assert_macros.svh.
//
// Usage:
//   req_ch  carries one glyph row per request with its metrics; accepted when
//           valid and ready are high at a rising clock edge.
//   rsp_ch  carries the byte offset, write mask and color of a visible row.
//           A fully clipped row gives no response.
//   csr_ch  writes one register per cycle (always ready); write only while idle.
// Throughput: one request per cycle while rsp_ch takes responses. The pen is
// updated at request accept, so back-to-back rows of consecutive glyphs need no gap.
// Path: a visible row passes the input register (loaded at accept), then the clip
// register, then the response register, which drives rsp_ch.
// Reset: clears all valid flags and the pen; clip registers and pitch go to 0,
// fore_color to 255.
// Stall: when rsp_ch is not ready the pipeline holds; up to three requests are
// in flight before req_ch.ready drops. Clipped rows drain even while stalled.
`include "assert_macros.svh"

module glyph_row_expand_blit #(
   parameter int MAX_GLYPH_WIDTH = gre_pkg::MAX_GLYPH_WIDTH_DEF
) (
   input  logic  clock,
   input  logic  reset,
   gre_req_if.sink   req_ch,
   gre_rsp_if.source rsp_ch,
   gre_csr_if.sink   csr_ch
);

   localparam int MW = MAX_GLYPH_WIDTH;

   gre_pkg::clip_cfg_type cfg_ff;
   logic [15:0]        pitch_ff;
   logic [7:0]         color_ff;
   logic signed [15:0] pen_start_ff;
   logic signed [15:0] pen_x_ff, pen_x_in;

   logic               s1_valid_ff, s1_valid_in;
   logic signed [15:0] s1_pen_ff;
   logic [MW-1:0]      s1_bits_ff;
   logic [6:0]         s1_width_ff;
   logic [5:0]         s1_row_ff;
   logic signed [7:0]  s1_bx_ff, s1_by_ff;

   logic               s2_valid_ff, s2_valid_in;
   gre_pkg::geo_type   s2_geo_ff, geo;
   logic [MW-1:0]      s2_bits_ff;

   logic               out_valid_ff, out_valid_in;
   logic [31:0]        out_offset_ff;
   logic [MW-1:0]      out_mask_ff;

   logic               req_accept, out_free, s2_go, s2_ready, s1_ready;
   logic signed [15:0] pen_eff;
   logic [6:0]         width_clamped;
   logic [MW-1:0]      shifted, mask;
   logic [31:0]        offset;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         pitch_ff     <= '0;
         color_ff     <= 8'hFF;
         pen_start_ff <= '0;
      end else if (csr_ch.valid) begin
         unique case (gre_pkg::csr_idx_type'(csr_ch.index))
            gre_pkg::CSR_CLIP_LEFT:      cfg_ff.clip_left      <= csr_ch.data;
            gre_pkg::CSR_CLIP_TOP:       cfg_ff.clip_top       <= csr_ch.data;
            gre_pkg::CSR_CLIP_RIGHT:     cfg_ff.clip_right     <= csr_ch.data;
            gre_pkg::CSR_CLIP_BOTTOM:    cfg_ff.clip_bottom    <= csr_ch.data;
            gre_pkg::CSR_DEST_PITCH:     pitch_ff              <= csr_ch.data;
            gre_pkg::CSR_FORE_COLOR:     color_ff              <= csr_ch.data[7:0];
            gre_pkg::CSR_PEN_START_X:    pen_start_ff          <= csr_ch.data;
            gre_pkg::CSR_PEN_BASELINE_Y: cfg_ff.pen_baseline_y <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // handshake chain
   always_comb begin
      out_free     = !out_valid_ff || rsp_ch.ready;
      s2_go        = !s2_geo_ff.visible || out_free;
      s2_ready     = !s2_valid_ff || s2_go;
      s1_ready     = !s1_valid_ff || s2_ready;
      req_accept   = req_ch.valid && s1_ready;
      s1_valid_in  = req_accept ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s2_ready ? s1_valid_ff : s2_valid_ff;
      out_valid_in = out_free ? (s2_valid_ff && s2_geo_ff.visible) : out_valid_ff;
   end

   assign req_ch.ready = s1_ready;

   // pen update at accept
   always_comb begin
      pen_eff       = req_ch.start_of_string ? pen_start_ff : pen_x_ff;
      pen_x_in      = pen_x_ff;
      if (req_accept) begin
         pen_x_in = pen_eff + (req_ch.last_row ? $signed({8'd0, req_ch.advance_x}) : 16'sd0);
      end
      width_clamped = (req_ch.glyph_width > 7'(MW)) ? 7'(MW) : req_ch.glyph_width;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pen_x_ff     <= pen_x_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pen_ff   <= pen_eff;
         s1_bits_ff  <= req_ch.row_bits;
         s1_width_ff <= width_clamped;
         s1_row_ff   <= req_ch.row_number;
         s1_bx_ff    <= req_ch.bearing_x;
         s1_by_ff    <= req_ch.bearing_y;
      end
   end

   gre_clip u_clip (
      .pen   (s1_pen_ff),
      .width (s1_width_ff),
      .row   (s1_row_ff),
      .bx    (s1_bx_ff),
      .by    (s1_by_ff),
      .cfg   (cfg_ff),
      .geo   (geo)
   );

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_geo_ff  <= geo;
         s2_bits_ff <= s1_bits_ff;
      end
   end

   // reset path clears visible through the valid flag only
   always_comb begin
      shifted = s2_bits_ff >> s2_geo_ff.skip;
      for (int i = 0; i < MW; i++) begin
         mask[i] = shifted[i] && (gre_pkg::COLS_W'(i) < s2_geo_ff.cols);
      end
      offset = s2_geo_ff.dy * pitch_ff + {16'd0, s2_geo_ff.dx};
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_offset_ff <= offset;
         out_mask_ff   <= mask;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.dest_offset = out_offset_ff;
   assign rsp_ch.write_mask  = out_mask_ff;
   assign rsp_ch.pixel_color = color_ff;

   `GRE_ASSERT_IMP(a_ready_low_full, clock, reset, !req_ch.ready, s1_valid_ff && s2_valid_ff && out_valid_ff)
   `GRE_ASSERT_NXT(a_s2_hold, clock, reset, s2_valid_ff && s2_geo_ff.visible && !out_free, s2_valid_ff && s2_geo_ff.visible)
   `GRE_ASSERT_IMP(a_visible_cols, clock, reset, s2_valid_ff && s2_geo_ff.visible, s2_geo_ff.cols != '0)

endmodule
